@@ sv/lobm_pkg.sv @@
package lobm_pkg;

	localparam int unsigned OID_W = 32;
	localparam int unsigned CID_W = 16;
	localparam int unsigned PX_W  = 32;
	localparam int unsigned QTY_W = 32;

	typedef enum logic [1:0] {
		TYPE_MARKET = 2'd0,
		TYPE_LIMIT  = 2'd1,
		TYPE_IOC    = 2'd2,
		TYPE_FOK    = 2'd3
	} order_type_t;

	typedef enum logic [2:0] {
		ST_RESTED    = 3'd0,
		ST_PARTIAL   = 3'd1,
		ST_FILLED    = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_REJECTED  = 3'd4,
		ST_BOOK_FULL = 3'd5
	} order_status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_MATCH,
		FSM_TRADE,
		FSM_POST,
		FSM_STATUS
	} fsm_state_t;

	typedef struct packed {
		logic [OID_W-1:0] order_id;
		logic [CID_W-1:0] client_id;
		logic             order_side;
		logic [1:0]       order_type;
		logic [PX_W-1:0]  limit_price;
		logic [QTY_W-1:0] order_quantity;
	} order_in_t;

	typedef struct packed {
		logic              result_kind;
		logic [31:0]       trade_id;
		logic [OID_W-1:0]  buy_order_id;
		logic [OID_W-1:0]  sell_order_id;
		logic [CID_W-1:0]  buy_client_id;
		logic [CID_W-1:0]  sell_client_id;
		logic [PX_W-1:0]   trade_price;
		logic [QTY_W-1:0]  trade_quantity;
		logic [2:0]        order_status;
		logic [QTY_W-1:0]  filled_quantity;
		logic              last_result;
	} result_out_t;

	typedef struct packed {
		logic [OID_W-1:0] oid;
		logic [CID_W-1:0] cid;
		logic [PX_W-1:0]  px;
		logic [QTY_W-1:0] rem;
		logic             val;
	} entry_t;

	// commands from the sequencer to one side's cell chain
	typedef struct packed {
		logic             pop;
		logic             dec;
		logic [QTY_W-1:0] dec_qty;
		logic             ins;
		entry_t           ins_entry;
	} side_cmd_t;

	// true when price a should sit ahead of b on this side (strictly better)
	function automatic logic better(input logic bids, input logic [PX_W-1:0] a,
		input logic [PX_W-1:0] b);
		better = bids ? (a > b) : (a < b);
	endfunction

endpackage

@@ sv/lobm_cell.sv @@
module lobm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bids,
	input  lobm_pkg::side_cmd_t cmd,
	input  lobm_pkg::entry_t  prev_e,
	input  logic              prev_is_head,
	input  lobm_pkg::entry_t  next_e,
	output lobm_pkg::entry_t  e
);
	import lobm_pkg::*;

	entry_t e_q;
	entry_t d;
	logic   prev_stays;
	logic   here_goes;

	// new entry lands after every entry of equal or better price
	assign prev_stays = prev_is_head ? 1'b1 :
		(prev_e.val && !better(bids, cmd.ins_entry.px, prev_e.px));
	assign here_goes = !e_q.val || better(bids, cmd.ins_entry.px, e_q.px);

	always_comb begin
		d = e_q;
		priority if (cmd.pop) begin
			d = next_e;
		end else if (cmd.ins) begin
			if (prev_stays && here_goes) begin
				d = cmd.ins_entry;
			end else if (!prev_stays) begin
				d = prev_e;
			end
		end else if (cmd.dec && prev_is_head) begin
			d.rem = e_q.rem - cmd.dec_qty;
		end else begin
			d = e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else begin
			e_q <= d;
		end
	end

	assign e = e_q;
endmodule

@@ sv/lobm_side.sv @@
module lobm_side #(
	parameter int unsigned BOOK_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          bids,
	input  lobm_pkg::side_cmd_t           cmd,
	input  logic [$clog2(BOOK_DEPTH)-1:0] peek_idx,
	output lobm_pkg::entry_t              head,
	output lobm_pkg::entry_t              peek,
	output lobm_pkg::entry_t              tail_view,
	output logic                          full
);
	import lobm_pkg::*;

	entry_t cells [BOOK_DEPTH];
	entry_t empty_e;

	assign empty_e = '0;

	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		lobm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.bids         (bids),
			.cmd          (cmd),
			.prev_e       ((i == 0) ? empty_e : cells[(i == 0) ? 0 : i-1]),
			.prev_is_head (i == 0),
			.next_e       ((i == BOOK_DEPTH-1) ? empty_e
				: cells[(i == BOOK_DEPTH-1) ? i : i+1]),
			.e            (cells[i])
		);
	end

	assign head      = cells[0];
	assign peek      = cells[peek_idx];
	assign tail_view = cells[BOOK_DEPTH-1];
	assign full      = cells[BOOK_DEPTH-1].val;
endmodule

@@ sv/lobm_seq.sv @@
module lobm_seq #(
	parameter int unsigned BOOK_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lobm_pkg::order_in_t           in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lobm_pkg::result_out_t         out_item,
	input  lobm_pkg::entry_t              bid_head,
	input  lobm_pkg::entry_t              ask_head,
	input  lobm_pkg::entry_t              bid_peek,
	input  lobm_pkg::entry_t              ask_peek,
	output logic [$clog2(BOOK_DEPTH)-1:0] peek_idx,
	input  logic                          bid_full,
	input  logic                          ask_full,
	output lobm_pkg::side_cmd_t           bid_cmd,
	output lobm_pkg::side_cmd_t           ask_cmd
);
	import lobm_pkg::*;

	localparam int unsigned IW = $clog2(BOOK_DEPTH);
	localparam int unsigned AW = QTY_W + IW + 1;

	fsm_state_t  state_q, state_d;
	order_in_t   ord_q;
	logic [QTY_W-1:0] remain_q, filled_q;
	logic [31:0] tid_q;
	logic [AW-1:0] avail_q;
	logic [IW-1:0] scan_q;
	logic [2:0]  status_q;
	result_out_t res_q, res_d;
	logic        res_v_q, res_v_d;

	logic   buy;
	entry_t opp_head;
	entry_t opp_peek;
	logic   acceptable;
	logic   peek_ok;
	logic   can_trade;
	logic   out_free;
	logic   take_trade;
	logic   scan_last;
	logic   scan_done;
	logic   fok_short;
	logic [AW-1:0] avail_d;
	logic [AW-1:0] qty_wide;
	logic [QTY_W-1:0] m;
	side_cmd_t own_cmd, opp_cmd;
	logic   own_full;

	assign buy        = !ord_q.order_side;
	assign opp_head   = buy ? ask_head : bid_head;
	assign opp_peek   = buy ? ask_peek : bid_peek;
	assign own_full   = buy ? bid_full : ask_full;
	assign acceptable = (ord_q.order_type == TYPE_MARKET) ? 1'b1 :
		(buy ? (ord_q.limit_price >= opp_head.px) : (ord_q.limit_price <= opp_head.px));
	assign can_trade  = (remain_q != '0) && opp_head.val && acceptable;
	assign m          = (remain_q < opp_head.rem) ? remain_q : opp_head.rem;
	assign out_free   = !res_v_q || out_ready;
	assign take_trade = (state_q == FSM_MATCH) && out_free && can_trade;

	// fill-or-kill scan of the opposite side, one entry per cycle
	assign peek_ok   = opp_peek.val &&
		(buy ? (ord_q.limit_price >= opp_peek.px) : (ord_q.limit_price <= opp_peek.px));
	assign qty_wide  = {{(AW-QTY_W){1'b0}}, ord_q.order_quantity};
	assign avail_d   = avail_q + (peek_ok ? {{(AW-QTY_W){1'b0}}, opp_peek.rem} : '0);
	assign scan_last = (scan_q == IW'(BOOK_DEPTH-1));
	assign scan_done = !peek_ok || scan_last || (avail_d >= qty_wide);
	assign fok_short = (avail_d < qty_wide);
	assign peek_idx  = scan_q;

	assign in_ready  = (state_q == FSM_IDLE);
	assign out_valid = res_v_q;
	assign out_item  = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE:   begin
				if (in_valid) begin
					if (in_item.order_type == TYPE_FOK) state_d = FSM_CHECK;
					else state_d = FSM_MATCH;
				end
			end
			FSM_CHECK:  begin
				if (scan_done) begin
					if (fok_short) state_d = FSM_STATUS;
					else state_d = FSM_MATCH;
				end
			end
			FSM_MATCH:  begin
				if (out_free) begin
					if (can_trade) state_d = FSM_TRADE;
					else state_d = FSM_POST;
				end
			end
			FSM_TRADE:  state_d = FSM_MATCH;
			FSM_POST:   state_d = FSM_STATUS;
			FSM_STATUS: if (out_free) state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		own_cmd = '0;
		opp_cmd = '0;
		if (take_trade) begin
			if (m == opp_head.rem) opp_cmd.pop = 1'b1;
			else begin
				opp_cmd.dec     = 1'b1;
				opp_cmd.dec_qty = m;
			end
		end
		if (state_q == FSM_POST && remain_q != '0 && ord_q.order_type == TYPE_LIMIT
			&& !own_full) begin
			own_cmd.ins           = 1'b1;
			own_cmd.ins_entry.oid = ord_q.order_id;
			own_cmd.ins_entry.cid = ord_q.client_id;
			own_cmd.ins_entry.px  = ord_q.limit_price;
			own_cmd.ins_entry.rem = remain_q;
			own_cmd.ins_entry.val = 1'b1;
		end
		bid_cmd = buy ? own_cmd : opp_cmd;
		ask_cmd = buy ? opp_cmd : own_cmd;
	end

	always_comb begin
		res_v_d = res_v_q && !out_ready;
		res_d   = res_q;
		if (take_trade) begin
			res_v_d              = 1'b1;
			res_d                = '0;
			res_d.trade_id       = tid_q;
			res_d.buy_order_id   = buy ? ord_q.order_id : opp_head.oid;
			res_d.sell_order_id  = buy ? opp_head.oid : ord_q.order_id;
			res_d.buy_client_id  = buy ? ord_q.client_id : opp_head.cid;
			res_d.sell_client_id = buy ? opp_head.cid : ord_q.client_id;
			res_d.trade_price    = opp_head.px;
			res_d.trade_quantity = m;
		end else if (state_q == FSM_STATUS && out_free) begin
			res_v_d               = 1'b1;
			res_d                 = '0;
			res_d.result_kind     = 1'b1;
			res_d.order_status    = status_q;
			res_d.filled_quantity = filled_q;
			res_d.last_result     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			res_v_q <= 1'b0;
			tid_q   <= 32'd1;
		end else begin
			state_q <= state_d;
			res_v_q <= res_v_d;
			if (take_trade) tid_q <= tid_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == FSM_IDLE && in_valid) begin
			ord_q    <= in_item;
			remain_q <= in_item.order_quantity;
			filled_q <= '0;
			avail_q  <= '0;
			scan_q   <= '0;
		end
		if (state_q == FSM_CHECK) begin
			avail_q <= avail_d;
			scan_q  <= scan_q + IW'(1);
			if (scan_done && fok_short) status_q <= ST_REJECTED;
		end
		if (take_trade) begin
			remain_q <= remain_q - m;
			filled_q <= filled_q + m;
		end
		if (state_q == FSM_POST) begin
			priority if (remain_q == '0) status_q <= ST_FILLED;
			else if (ord_q.order_type == TYPE_LIMIT) begin
				if (own_full) status_q <= ST_BOOK_FULL;
				else status_q <= (filled_q != '0) ? ST_PARTIAL : ST_RESTED;
			end else if (ord_q.order_type == TYPE_FOK) status_q <= ST_REJECTED;
			else status_q <= ST_CANCELLED;
		end
	end
endmodule

@@ sv/limit_order_book_matcher.sv @@
// trades are registered from the MATCH state, the final status from the STATUS state
// fill-or-kill first scans the opposite side, at most BOOK_DEPTH entries
// a new order is accepted only in the idle state, after the previous order's status is issued
// trades step through the head cell of the opposite side's cell chain
// reset: both sides empty, next trade number 1, no result pending
module limit_order_book_matcher #(
	parameter int unsigned BOOK_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lobm_pkg::order_in_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lobm_pkg::result_out_t out_data
);
	import lobm_pkg::*;

	entry_t    bid_head, ask_head, bid_tail, ask_tail;
	entry_t    bid_peek, ask_peek;
	logic      bid_full, ask_full;
	side_cmd_t bid_cmd, ask_cmd;
	logic [$clog2(BOOK_DEPTH)-1:0] peek_idx;

	lobm_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
		.clk(clk), .arst_n(arst_n), .bids(1'b1), .cmd(bid_cmd), .peek_idx(peek_idx),
		.head(bid_head), .peek(bid_peek), .tail_view(bid_tail), .full(bid_full)
	);

	lobm_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
		.clk(clk), .arst_n(arst_n), .bids(1'b0), .cmd(ask_cmd), .peek_idx(peek_idx),
		.head(ask_head), .peek(ask_peek), .tail_view(ask_tail), .full(ask_full)
	);

	lobm_seq #(.BOOK_DEPTH(BOOK_DEPTH)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
		.bid_head(bid_head), .ask_head(ask_head),
		.bid_peek(bid_peek), .ask_peek(ask_peek), .peek_idx(peek_idx),
		.bid_full(bid_full && bid_tail.val), .ask_full(ask_full && ask_tail.val),
		.bid_cmd(bid_cmd), .ask_cmd(ask_cmd)
	);
endmodule

@@ sv/lobm_checker.sv @@
module lobm_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input lobm_pkg::result_out_t out_data
);
	import lobm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output dropped while stalled");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_result |-> out_data.result_kind)
		else $error("last flag on trade record");

	a_trade_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_kind |-> out_data.order_status == ST_RESTED)
		else $error("status code in trade record");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind |-> out_data.order_status <= ST_BOOK_FULL)
		else $error("status code out of range");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ tb/limit_order_book_matcher_tb.sv @@
`timescale 1ns / 100ps

module limit_order_book_matcher_tb;
	import lobm_pkg::*;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	order_in_t   in_data;
	logic        out_valid;
	logic        out_ready;
	result_out_t out_data;

	limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	typedef struct {
		logic [OID_W-1:0] oid;
		logic [CID_W-1:0] cid;
		logic [PX_W-1:0]  px;
		logic [QTY_W-1:0] rem;
	} resting_t;

	resting_t    bids[$];
	resting_t    asks[$];
	logic [31:0] trade_seq;
	result_out_t expected_results[$];
	int          errors;
	int          idle_pct;
	int unsigned quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic px_ok(logic buy, logic mkt, logic [PX_W-1:0] lim,
		logic [PX_W-1:0] px);
		if (mkt)
			return 1'b1;
		return buy ? (lim >= px) : (lim <= px);
	endfunction

	task automatic queue_expected(input result_out_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// match one order against the book and queue the trades and status it yields
	task automatic match_order(input order_in_t o);
		logic             buy;
		logic             mkt;
		logic [QTY_W-1:0] remaining;
		logic [QTY_W-1:0] filled;
		logic [QTY_W-1:0] m;
		logic [63:0]      avail;
		logic [2:0]       st;
		int               pos;
		result_out_t      r;
		resting_t         e;
		resting_t         opp[$];
		buy = (o.order_side == 1'b0);
		mkt = (o.order_type == TYPE_MARKET);
		remaining = o.order_quantity;
		filled = '0;
		opp = buy ? asks : bids;
		if (o.order_type == TYPE_FOK) begin
			avail = '0;
			foreach (opp[i]) begin
				if (!px_ok(buy, 1'b0, o.limit_price, opp[i].px))
					break;
				avail += opp[i].rem;
			end
			if (avail < {32'd0, o.order_quantity}) begin
				r = '0;
				r.result_kind = 1'b1;
				r.order_status = ST_REJECTED;
				r.last_result = 1'b1;
				queue_expected(r);
				return;
			end
		end
		while (remaining > 0 && opp.size() > 0 && px_ok(buy, mkt, o.limit_price, opp[0].px)) begin
			m = (remaining < opp[0].rem) ? remaining : opp[0].rem;
			r = '0;
			r.trade_id = trade_seq;
			r.trade_price = opp[0].px;
			r.trade_quantity = m;
			if (buy) begin
				r.buy_order_id = o.order_id;
				r.buy_client_id = o.client_id;
				r.sell_order_id = opp[0].oid;
				r.sell_client_id = opp[0].cid;
			end else begin
				r.sell_order_id = o.order_id;
				r.sell_client_id = o.client_id;
				r.buy_order_id = opp[0].oid;
				r.buy_client_id = opp[0].cid;
			end
			queue_expected(r);
			trade_seq++;
			opp[0].rem -= m;
			remaining -= m;
			filled += m;
			if (opp[0].rem == 0)
				void'(opp.pop_front());
		end
		if (buy)
			asks = opp;
		else
			bids = opp;
		if (remaining == 0)
			st = ST_FILLED;
		else if (o.order_type == TYPE_LIMIT) begin
			opp = buy ? bids : asks;
			if (opp.size() >= DEPTH)
				st = ST_BOOK_FULL;
			else begin
				pos = 0;
				while (pos < opp.size() &&
					!(buy ? opp[pos].px < o.limit_price : opp[pos].px > o.limit_price))
					pos++;
				e.oid = o.order_id;
				e.cid = o.client_id;
				e.px = o.limit_price;
				e.rem = remaining;
				opp.insert(pos, e);
				st = (filled != 0) ? ST_PARTIAL : ST_RESTED;
			end
			if (buy)
				bids = opp;
			else
				asks = opp;
		end else if (o.order_type == TYPE_FOK)
			st = ST_REJECTED;
		else
			st = ST_CANCELLED;
		r = '0;
		r.result_kind = 1'b1;
		r.order_status = st;
		r.filled_quantity = filled;
		r.last_result = 1'b1;
		queue_expected(r);
	endtask

	task automatic send_order(input order_in_t o);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		match_order(o);
		in_valid <= 1'b1;
		in_data <= o;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic order_in_t mk(logic side, order_type_t t, logic [31:0] px,
		logic [31:0] qty);
		order_in_t o;
		o.order_id = $urandom;
		o.client_id = 16'($urandom);
		o.order_side = side;
		o.order_type = t;
		o.limit_price = px;
		o.order_quantity = qty;
		return o;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic test_directed();
		order_in_t o;
		send_order(mk(1'b0, TYPE_MARKET, 32'd5, 32'd10));
		send_order(mk(1'b1, TYPE_IOC, 32'd5, 32'd10));
		send_order(mk(1'b0, TYPE_LIMIT, 32'd100, 32'd50));
		send_order(mk(1'b0, TYPE_LIMIT, 32'd100, 32'd20));
		send_order(mk(1'b0, TYPE_LIMIT, 32'd0, 32'd7));
		send_order(mk(1'b1, TYPE_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_order(mk(1'b1, TYPE_LIMIT, 32'd200, 32'd30));
		send_order(mk(1'b1, TYPE_FOK, 32'd100, 32'd1000));
		send_order(mk(1'b1, TYPE_FOK, 32'd100, 32'd60));
		send_order(mk(1'b1, TYPE_LIMIT, 32'd90, 32'd40));
		send_order(mk(1'b0, TYPE_IOC, 32'd150, 32'd100));
		send_order(mk(1'b0, TYPE_FOK, 32'hFFFF_FFFF, 32'd5));
		send_order(mk(1'b1, TYPE_MARKET, 32'd0, 32'd100));
		send_order(mk(1'b1, TYPE_LIMIT, 32'd7, 32'd0));
		o = mk(1'b0, TYPE_MARKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		o.order_id = '1;
		o.client_id = '1;
		send_order(o);
		o = mk(1'b1, TYPE_LIMIT, 32'd0, 32'd1);
		o.order_id = '0;
		o.client_id = '0;
		send_order(o);
		wait_drained();
	endtask

	// fill one side to capacity so the next limit remainder is dropped
	task automatic test_book_full();
		for (int i = 0; i < DEPTH + 2; i++)
			send_order(mk(1'b0, TYPE_LIMIT, $urandom_range(10, 20), $urandom_range(1, 9)));
		send_order(mk(1'b1, TYPE_MARKET, 32'd0, 32'hFFFF_FFFF));
		wait_drained();
	endtask

	task automatic test_random(input int n);
		order_in_t o;
		for (int i = 0; i < n; i++) begin
			o = mk(1'($urandom_range(1)), order_type_t'($urandom_range(3)), 32'd0, 32'd0);
			if ($urandom_range(9) < 8) begin
				o.limit_price = $urandom_range(90, 110);
				o.order_quantity = $urandom_range(1, 40);
			end else begin
				o.limit_price = $urandom;
				o.order_quantity = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
			end
			if ($urandom_range(3) == 0)
				o.order_type = TYPE_LIMIT;
			send_order(o);
			if (i == n / 2)
				wait_drained();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		result_out_t x;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transfer %h", out_data);
				errors++;
			end else begin
				x = expected_results.pop_front();
				if (out_data.result_kind !== x.result_kind) begin
					$error("result_kind exp %h got %h", x.result_kind, out_data.result_kind);
					errors++;
				end
				if (out_data.trade_id !== x.trade_id) begin
					$error("trade_id exp %h got %h", x.trade_id, out_data.trade_id);
					errors++;
				end
				if (out_data.buy_order_id !== x.buy_order_id) begin
					$error("buy_order_id exp %h got %h", x.buy_order_id, out_data.buy_order_id);
					errors++;
				end
				if (out_data.sell_order_id !== x.sell_order_id) begin
					$error("sell_order_id exp %h got %h", x.sell_order_id,
						out_data.sell_order_id);
					errors++;
				end
				if (out_data.buy_client_id !== x.buy_client_id) begin
					$error("buy_client_id exp %h got %h", x.buy_client_id,
						out_data.buy_client_id);
					errors++;
				end
				if (out_data.sell_client_id !== x.sell_client_id) begin
					$error("sell_client_id exp %h got %h", x.sell_client_id,
						out_data.sell_client_id);
					errors++;
				end
				if (out_data.trade_price !== x.trade_price) begin
					$error("trade_price exp %h got %h", x.trade_price, out_data.trade_price);
					errors++;
				end
				if (out_data.trade_quantity !== x.trade_quantity) begin
					$error("trade_quantity exp %h got %h", x.trade_quantity,
						out_data.trade_quantity);
					errors++;
				end
				if (out_data.order_status !== x.order_status) begin
					$error("order_status exp %h got %h", x.order_status, out_data.order_status);
					errors++;
				end
				if (out_data.filled_quantity !== x.filled_quantity) begin
					$error("filled_quantity exp %h got %h", x.filled_quantity,
						out_data.filled_quantity);
					errors++;
				end
				if (out_data.last_result !== x.last_result) begin
					$error("last_result exp %h got %h", x.last_result, out_data.last_result);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		errors = 0;
		idle_pct = 32;
		quiet_cycles = 0;
		trade_seq = 32'd1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_book_full();
		idle_pct = 0;
		test_random(40);
		idle_pct = 32;
		test_random(90);
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
